FILE: hw/rtl/bps_pkg.sv
`timescale 1ns / 1ps
package bps_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxArea   = 15;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned PosW      = 17;
  localparam int unsigned SizeW     = 4;
  localparam int unsigned DimW      = 9;

  localparam logic [1:0] OpWrite    = 2'd0;
  localparam logic [1:0] OpBilinear = 2'd1;
  localparam logic [1:0] OpArea     = 2'd2;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegLoaded = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture the accepted item
    logic       win_init;  // start window at top-left offset
    logic       win_step;  // advance window position
    logic [1:0] rd_sel;    // which neighbor to read
    logic       rd_en;
    logic       mac;       // fold read pixel into blend
    logic       acc;       // accumulate finished sample
    logic       div_start;
    logic       div_step;
    logic       finish;    // move result into output register
  } bps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_write;
    logic op_sample;
    logic op_area;
    logic area_ok;   // loaded and size nonzero
    logic pos_ok;    // current window position valid
    logic win_last;
    logic div_done;
  } bps_sts_t;
endpackage

FILE: hw/rtl/bps_ctrl.sv
`timescale 1ns / 1ps
module bps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  bps_pkg::bps_sts_t sts_i,
  output bps_pkg::bps_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    StIdle, StDecode, StCheck, StRead, StBlend, StAcc, StDiv, StDone, StOut
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] nb_q, nb_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    nb_d        = nb_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        cmd_o.win_init = 1'b1;
        if (sts_i.op_write) begin
          state_d = StIdle;
        end else if (sts_i.op_sample || (sts_i.op_area && sts_i.area_ok)) begin
          state_d = StCheck;
        end else if (sts_i.op_area) begin
          state_d = StDone;
        end else begin
          state_d = StIdle;
        end
      end
      StCheck: begin
        nb_d = 2'd0;
        if (sts_i.pos_ok) begin
          state_d = StRead;
        end else if (sts_i.win_last) begin
          state_d = StDone;
        end else begin
          cmd_o.win_step = 1'b1;
        end
      end
      StRead: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = nb_q;
        state_d      = StBlend;
      end
      StBlend: begin
        cmd_o.mac    = 1'b1;
        cmd_o.rd_sel = nb_q;
        nb_d         = nb_q + 2'd1;
        state_d      = (nb_q == 2'd3) ? StAcc : StRead;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        if (sts_i.win_last) begin
          state_d = StDone;
        end else begin
          cmd_o.win_step = 1'b1;
          state_d        = StCheck;
        end
      end
      StDone: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      nb_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

FILE: hw/rtl/bps_datapath.sv
`timescale 1ns / 1ps
module bps_datapath #(
  parameter int unsigned MAX_WIDTH  = bps_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = bps_pkg::MaxHeight,
  parameter int unsigned MAX_AREA   = bps_pkg::MaxArea,
  parameter int unsigned FRAC_BITS  = bps_pkg::FracBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bps_pkg::bps_cmd_t         cmd_i,
  output bps_pkg::bps_sts_t         sts_o,
  input  logic [bps_pkg::DimW-1:0]  width_i,
  input  logic [bps_pkg::DimW-1:0]  height_i,
  input  logic                      loaded_i,
  input  logic [1:0]                op_i,
  input  logic signed [bps_pkg::PosW-1:0] x_pos_i,
  input  logic signed [bps_pkg::PosW-1:0] y_pos_i,
  input  logic [bps_pkg::SizeW-1:0] area_size_i,
  input  logic [7:0]                red_in_i,
  input  logic [7:0]                green_in_i,
  input  logic [7:0]                blue_in_i,
  output logic [7:0]                red_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                blue_out_o,
  output logic                      in_range_o
);
  localparam int unsigned PosW  = bps_pkg::PosW;
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned HalfW = $clog2(MAX_AREA / 2 + 2) + 1;
  // window offsets and positions, signed, wide enough for any shift
  localparam int unsigned WPW   = PosW + HalfW + FRAC_BITS + 1;
  localparam int unsigned CntW  = $clog2(MAX_AREA * MAX_AREA + 1);
  localparam int unsigned SumW  = 8 + CntW;
  localparam int unsigned EW    = (XW > YW ? XW : YW) + 1;
  localparam int unsigned OneW  = FRAC_BITS + 1;
  localparam int unsigned WtW   = 2 * FRAC_BITS + 2;
  localparam int unsigned AccW  = 8 + WtW;

  // captured item
  logic [1:0]                op_q;
  logic signed [PosW-1:0]    x_q, y_q;
  logic [bps_pkg::SizeW-1:0] size_q;
  logic [23:0]               wpix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      x_q    <= x_pos_i;
      y_q    <= y_pos_i;
      size_q <= area_size_i;
      wpix_q <= {red_in_i, green_in_i, blue_in_i};
    end
  end

  // effective dimensions
  logic [EW-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = (32'(width_i) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(width_i);
    h_eff = (32'(height_i) > MAX_HEIGHT) ? EW'(MAX_HEIGHT) : EW'(height_i);
  end

  // size: saturate then make odd; half side
  logic [HalfW-1:0] half;
  always_comb begin
    logic [7:0] s;
    s = (32'(size_q) > MAX_AREA) ? 8'(MAX_AREA) : 8'(size_q);
    s = s | 8'd1;
    half = HalfW'(s >> 1);
  end

  logic signed [HalfW:0] dx_q, dy_q;
  logic signed [WPW-1:0] sx, sy;
  assign sx = WPW'(x_q) + (WPW'(dx_q) <<< FRAC_BITS);
  assign sy = WPW'(y_q) + (WPW'(dy_q) <<< FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      if (op_q == bps_pkg::OpArea) begin
        dx_q <= -$signed({1'b0, half});
        dy_q <= -$signed({1'b0, half});
      end else begin
        dx_q <= '0;
        dy_q <= '0;
      end
    end else if (cmd_i.win_step) begin
      if (dx_q == $signed({1'b0, half})) begin
        dx_q <= -$signed({1'b0, half});
        dy_q <= dy_q + 1'b1;
      end else begin
        dx_q <= dx_q + 1'b1;
      end
    end
  end

  logic pos_ok, win_last;
  logic [WPW-1:0] wlim, hlim;
  assign wlim = WPW'(w_eff) << FRAC_BITS;
  assign hlim = WPW'(h_eff) << FRAC_BITS;
  assign pos_ok = loaded_i && !sx[WPW-1] && !sy[WPW-1] &&
                  (sx < $signed(wlim)) && (sy < $signed(hlim));
  assign win_last = (op_q != bps_pkg::OpArea) ||
                    ((dx_q == $signed({1'b0, half})) && (dy_q == $signed({1'b0, half})));

  // neighbor coordinates
  logic [EW-1:0] x1, y1, x2, y2;
  always_comb begin
    x1 = EW'(sx >>> FRAC_BITS);
    y1 = EW'(sy >>> FRAC_BITS);
    x2 = (x1 + 1'b1 < w_eff) ? x1 + 1'b1 : w_eff - 1'b1;
    y2 = (y1 + 1'b1 < h_eff) ? y1 + 1'b1 : h_eff - 1'b1;
  end

  logic [FRAC_BITS-1:0] fx, fy;
  assign fx = sx[FRAC_BITS-1:0];
  assign fy = sy[FRAC_BITS-1:0];

  // pixel store, single port
  logic [23:0] mem [Depth];
  logic [23:0] rdata_q;
  logic [EW-1:0] rx, ry;
  always_comb begin
    rx = cmd_i.rd_sel[0] ? x2 : x1;
    ry = cmd_i.rd_sel[1] ? y2 : y1;
  end

  logic wr_ok;
  logic [AW-1:0] waddr;
  assign wr_ok = (op_q == bps_pkg::OpWrite) && !x_q[PosW-1] && !y_q[PosW-1] &&
                 (32'(x_q[PosW-2:FRAC_BITS]) < MAX_WIDTH) &&
                 (32'(y_q[PosW-2:FRAC_BITS]) < MAX_HEIGHT);
  assign waddr = {YW'(y_q[PosW-2:FRAC_BITS]), XW'(x_q[PosW-2:FRAC_BITS])};

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init && wr_ok) begin
      mem[waddr] <= wpix_q;
    end else if (cmd_i.rd_en) begin
      rdata_q <= mem[{YW'(ry), XW'(rx)}];
    end
  end

  // blend weight for neighbor: (ONE-fx or fx)*(ONE-fy or fy)
  logic [OneW-1:0] wx, wy;
  logic [WtW-1:0]  wt;
  assign wx = cmd_i.rd_sel[0] ? OneW'(fx) : OneW'((1 << FRAC_BITS) - fx);
  assign wy = cmd_i.rd_sel[1] ? OneW'(fy) : OneW'((1 << FRAC_BITS) - fy);
  assign wt = WtW'(wx) * WtW'(wy);

  logic [AccW-1:0] bl_q [3];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.rd_en && cmd_i.rd_sel == 2'd0) begin
        bl_q[c] <= '0;
      end else if (cmd_i.mac) begin
        bl_q[c] <= bl_q[c] + AccW'(rdata_q[8*c +: 8]) * AccW'(wt);
      end
    end
  end

  logic [SumW-1:0] sum_q [3];
  logic [CntW-1:0] cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.win_init) begin
      cnt_q <= '0;
    end else if (cmd_i.acc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.win_init) begin
        sum_q[c] <= '0;
      end else if (cmd_i.acc) begin
        sum_q[c] <= sum_q[c] + SumW'(bl_q[c][2*FRAC_BITS +: 8]);
      end
    end
  end

  // restoring divider, all three channels share the step counter
  localparam int unsigned StW = $clog2(SumW + 1);
  logic [SumW-1:0] rem_q [3];
  logic [SumW-1:0] quo_q [3];
  logic [StW-1:0]  step_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      step_q <= '0;
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= '0;
        quo_q[c] <= sum_q[c];
      end
    end else if (cmd_i.div_step && 32'(step_q) < SumW) begin
      step_q <= step_q + 1'b1;
      for (int c = 0; c < 3; c++) begin
        logic [SumW:0] t;
        t = {rem_q[c], quo_q[c][SumW-1]};
        if (t >= (SumW+1)'(cnt_q)) begin
          rem_q[c] <= SumW'(t - (SumW+1)'(cnt_q));
          quo_q[c] <= {quo_q[c][SumW-2:0], 1'b1};
        end else begin
          rem_q[c] <= SumW'(t);
          quo_q[c] <= {quo_q[c][SumW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (cnt_q == '0) begin
        {red_out_o, green_out_o, blue_out_o} <= '0;
        in_range_o <= 1'b0;
      end else begin
        red_out_o   <= quo_q[2][7:0];
        green_out_o <= quo_q[1][7:0];
        blue_out_o  <= quo_q[0][7:0];
        in_range_o  <= 1'b1;
      end
    end
  end

  assign sts_o.op_write  = (op_q == bps_pkg::OpWrite);
  assign sts_o.op_sample = (op_q == bps_pkg::OpBilinear);
  assign sts_o.op_area   = (op_q == bps_pkg::OpArea);
  assign sts_o.area_ok   = loaded_i && (size_q != '0);
  assign sts_o.pos_ok    = pos_ok;
  assign sts_o.win_last  = win_last;
  assign sts_o.div_done  = (32'(step_q) >= SumW);
endmodule

FILE: hw/rtl/bilinear_pixel_sampler_top.sv
`timescale 1ns / 1ps
// Channel | Handshake            | Payload
// in      | in_valid_i/in_ready_o | op, x_pos, y_pos, area_size, red/green/blue_in
// out     | out_valid_o/out_ready_i | red/green/blue_out, in_range
// cfg     | APB psel/penable      | image_width, image_height, image_loaded
// One item at a time. Bilinear sample time is set by four reads from the
// single-port pixel store and the shared bit-serial divider. Area average time
// grows with each in-image sample and each skipped position, plus the divider.
// Reset clears control, config registers and sample count, not the pixel store
// or other datapath state. A stalled output holds the block before the next item.
module bilinear_pixel_sampler_top #(
  parameter int unsigned MAX_WIDTH  = bps_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = bps_pkg::MaxHeight,
  parameter int unsigned MAX_AREA   = bps_pkg::MaxArea,
  parameter int unsigned FRAC_BITS  = bps_pkg::FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic signed [16:0] x_pos_i,
  input  logic signed [16:0] y_pos_i,
  input  logic [3:0]  area_size_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        in_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [8:0] width_q, height_q;
  logic       loaded_q;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      loaded_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        bps_pkg::RegWidth:  width_q  <= pwdata[8:0];
        bps_pkg::RegHeight: height_q <= pwdata[8:0];
        bps_pkg::RegLoaded: loaded_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bps_pkg::RegWidth:  prdata = {23'd0, width_q};
      bps_pkg::RegHeight: prdata = {23'd0, height_q};
      bps_pkg::RegLoaded: prdata = {31'd0, loaded_q};
      default:            prdata = '0;
    endcase
  end

  bps_pkg::bps_cmd_t cmd;
  bps_pkg::bps_sts_t sts;

  bps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i, .out_valid_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  bps_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_AREA(MAX_AREA), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .width_i(width_q), .height_i(height_q), .loaded_i(loaded_q),
    .op_i, .x_pos_i, .y_pos_i, .area_size_i, .red_in_i, .green_in_i, .blue_in_i,
    .red_out_o, .green_out_o, .blue_out_o, .in_range_o
  );
endmodule

FILE: hw/rtl/bps_checker.sv
`timescale 1ns / 1ps
module bps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_out_o,
  input logic       in_range_o,
  input logic       pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("out item dropped");
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> red_out_o == 8'd0) else $error("not black");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("took two items");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");
endmodule

bind bilinear_pixel_sampler_top bps_checker u_chk (.*);
